// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/ffea_pkg.sv
// Shared types and constants for the first-fit extent allocator.
package ffea_pkg;

  localparam int LEN_W       = 26;
  localparam int TUSER_W     = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;
  localparam int OFF_W       = 32;
  localparam int SIZE_W      = 32;

  localparam logic [LEN_W-1:0] LEN_MAX    = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] POOL_RESET = 26'd131072;

  localparam int DEF_MAX_EXTENTS   = 64;
  localparam int DEF_GRANULE_BYTES = 128;
  localparam int DEF_ADDR_BITS     = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_INIT  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } res_status_t;

  typedef enum logic [3:0] {
    S_BOOT,
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_ALLOC,
    S_FREE,
    S_LINK,
    S_INIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic boot_wr;
    logic accept;
    logic read_cur;
    logic eval;
    logic close;
    logic alloc_upd;
    logic free_upd;
    logic link_upd;
    logic init;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic walk_end;
    logic stop;
    logic need_link;
    logic out_free;
  } sts_t;

endpackage

// File: hdl/ffea_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ffea_ctrl.sv
// Request sequencer: walks the extent list and orders the table updates.
module ffea_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ffea_pkg::TUSER_W-1:0]  in_req,
  input  ffea_pkg::sts_t                sts,
  output ffea_pkg::cmd_t                cmd,
  output ffea_pkg::state_t              state
);

  ffea_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffea_pkg::S_BOOT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ffea_pkg::S_BOOT: begin
        cmd.boot_wr = 1'b1;
        state_nxt   = ffea_pkg::S_IDLE;
      end
      ffea_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ffea_pkg::S_DONE;
        end
      end
      ffea_pkg::S_CHECK: begin
        if (sts.walk_end) begin
          cmd.close = 1'b1;
          state_nxt = (sts.req == ffea_pkg::REQ_ALLOC) ? ffea_pkg::S_DONE : ffea_pkg::S_FREE;
        end else begin
          cmd.read_cur = 1'b1;
          state_nxt    = ffea_pkg::S_EVAL;
        end
      end
      ffea_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (!sts.stop) begin
          state_nxt = ffea_pkg::S_CHECK;
        end else begin
          state_nxt = (sts.req == ffea_pkg::REQ_ALLOC) ? ffea_pkg::S_ALLOC : ffea_pkg::S_FREE;
        end
      end
      ffea_pkg::S_ALLOC: begin
        cmd.alloc_upd = 1'b1;
        state_nxt     = ffea_pkg::S_DONE;
      end
      ffea_pkg::S_FREE: begin
        cmd.free_upd = 1'b1;
        state_nxt    = sts.need_link ? ffea_pkg::S_LINK : ffea_pkg::S_DONE;
      end
      ffea_pkg::S_LINK: begin
        cmd.link_upd = 1'b1;
        state_nxt    = ffea_pkg::S_DONE;
      end
      ffea_pkg::S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = ffea_pkg::S_DONE;
      end
      ffea_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ffea_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffea_pkg::S_IDLE;
      end
    endcase
    // route an accepted word by the request kind it carries
    if (cmd.accept) begin
      unique case (ffea_pkg::req_t'(in_req))
        ffea_pkg::REQ_ALLOC: state_nxt = ffea_pkg::S_CHECK;
        ffea_pkg::REQ_FREE:  state_nxt = ffea_pkg::S_CHECK;
        ffea_pkg::REQ_INIT:  state_nxt = ffea_pkg::S_INIT;
        ffea_pkg::REQ_NOP:   state_nxt = ffea_pkg::S_DONE;
        default:             state_nxt = ffea_pkg::S_DONE;
      endcase
    end
  end

  assign state = state_r;

endmodule

// File: hdl/ffea_dp.sv
// Extent table, walk registers, counters and the result register.
module ffea_dp #(
  parameter int MAX_EXTENTS   = ffea_pkg::DEF_MAX_EXTENTS,
  parameter int GRANULE_BYTES = ffea_pkg::DEF_GRANULE_BYTES,
  parameter int ADDR_BITS     = ffea_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ffea_pkg::LEN_W-1:0]          cfg_wr_data,
  input  logic [ffea_pkg::TUSER_W-1:0]        in_req,
  input  logic [ffea_pkg::SIZE_W-1:0]         in_size,
  input  logic [ffea_pkg::OFF_W-1:0]          in_off,
  input  ffea_pkg::cmd_t                      cmd,
  output ffea_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ffea_pkg::TUSER_W-1:0]        out_status,
  output logic [ffea_pkg::OFF_W-1:0]          out_off,
  output logic [ffea_pkg::LEN_W-1:0]          out_avail
);

  localparam int LEN_W   = ffea_pkg::LEN_W;
  localparam int GL      = $clog2(GRANULE_BYTES);
  localparam int IW      = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW      = $clog2(MAX_EXTENTS) + 1;
  localparam int AB      = (ADDR_BITS < ffea_pkg::OFF_W) ? ADDR_BITS : ffea_pkg::OFF_W;
  localparam int START_W = AB - GL;
  localparam int EXT_SW  = ((START_W > LEN_W) ? START_W : LEN_W) + 1;
  localparam int G_W     = ffea_pkg::SIZE_W + 1 - GL;
  localparam int SUM_W   = ((EXT_SW > G_W) ? EXT_SW : G_W) + 1;
  localparam int WORD_W  = EXT_SW + LEN_W + IW;
  localparam int SIZE_W_SUM = ffea_pkg::SIZE_W;

  localparam longint unsigned LIMIT   = (64'd1 << ADDR_BITS) / GRANULE_BYTES;
  localparam longint unsigned LMAX_L  = (64'd1 << LEN_W) - 64'd1;
  localparam longint unsigned CLAMP_L = (LIMIT > LMAX_L) ? LMAX_L : LIMIT;
  localparam logic [LEN_W-1:0] CLAMP  = CLAMP_L[LEN_W-1:0];
  localparam logic [LEN_W-1:0] RESET_P =
    (ffea_pkg::POOL_RESET > CLAMP) ? CLAMP : ffea_pkg::POOL_RESET;
  localparam logic [IW:0]   NO_SLOT = (IW+1)'(MAX_EXTENTS);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

  // control state
  logic [LEN_W-1:0]       pool_r;
  logic [IW:0]            head_r;
  logic [LEN_W-1:0]       total_r;
  logic [MAX_EXTENTS-1:0] in_use_r;
  logic                   out_valid_r;

  // walk and request payload
  ffea_pkg::req_t         req_r;
  logic [G_W-1:0]         g_r;
  logic [START_W-1:0]     start_r;
  logic [IW:0]            cur_r, prev_r, slot_r;
  logic [CW-1:0]          steps_r;
  logic [EXT_SW-1:0]      cur_start_r, prev_start_r;
  logic [LEN_W-1:0]       cur_len_r, prev_len_r;
  logic [IW-1:0]          cur_link_r;
  logic [IW-1:0]          prev_link_r;
  ffea_pkg::res_status_t  res_status_r;
  logic [EXT_SW-1:0]      res_start_r;
  logic                   res_ok_r;
  logic [ffea_pkg::TUSER_W-1:0] out_status_r;
  logic [ffea_pkg::OFF_W-1:0]   out_off_r;
  logic [LEN_W-1:0]             out_avail_r;

  // table port
  logic              we;
  logic [IW-1:0]     waddr;
  logic [WORD_W-1:0] wdata, rdata;
  logic [EXT_SW-1:0] rd_start;
  logic [LEN_W-1:0]  rd_len;
  logic [IW-1:0]     rd_link;

  logic [SIZE_W_SUM:0] size_sum_dummy;

  logic [G_W-1:0]    g_in;
  logic [IW:0]       free_slot;
  logic [IW:0]       rd_next, cur_next;
  logic              mprev, mnext;
  logic [SUM_W-1:0]  s_new_end, s_prev_end, s_cur_start, s_cur_len, s_g;
  logic [SUM_W-1:0]  s_gcur, s_all, s_tot, s_pg;
  logic [LEN_W-1:0]  gcur_sat, all_sat, tot_sat, pg_sat, g_sat, pool_p;
  logic [LEN_W-1:0]  tot_sub;

  function automatic logic [LEN_W-1:0] sat(input logic [SUM_W-1:0] x);
    sat = (x > SUM_W'(ffea_pkg::LEN_MAX)) ? ffea_pkg::LEN_MAX : x[LEN_W-1:0];
  endfunction

  function automatic logic [ffea_pkg::OFF_W-1:0] off_bytes(input logic [EXT_SW-1:0] st);
    logic [EXT_SW+GL+ffea_pkg::OFF_W-1:0] w;
    w = {ffea_pkg::OFF_W'(0), st, GL'(0)};
    off_bytes = w[ffea_pkg::OFF_W-1:0];
  endfunction

  ffea_ram #(.WIDTH(WORD_W), .DEPTH(MAX_EXTENTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.read_cur),
    .raddr (cur_r[IW-1:0]),
    .rdata (rdata)
  );

  assign size_sum_dummy = {1'b0, in_size} + (SIZE_W_SUM+1)'(GRANULE_BYTES - 1);
  assign g_in = (size_sum_dummy[SIZE_W_SUM:GL] == '0) ? G_W'(1) : size_sum_dummy[SIZE_W_SUM:GL];

  assign {rd_link, rd_len, rd_start} = rdata;
  assign rd_next  = (rd_link == cur_r[IW-1:0]) ? NO_SLOT : {1'b0, rd_link};
  assign cur_next = (cur_link_r == cur_r[IW-1:0]) ? NO_SLOT : {1'b0, cur_link_r};

  // lowest unused slot
  always_comb begin
    free_slot = NO_SLOT;
    for (int i = MAX_EXTENTS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_slot = (IW+1)'(i);
      end
    end
  end

  assign s_g         = SUM_W'(g_r);
  assign s_cur_start = SUM_W'(cur_start_r);
  assign s_cur_len   = SUM_W'(cur_len_r);
  assign s_new_end   = SUM_W'(start_r) + s_g;
  assign s_prev_end  = SUM_W'(prev_start_r) + SUM_W'(prev_len_r);
  assign mnext = (cur_r != NO_SLOT) && (s_new_end == s_cur_start);
  assign mprev = (prev_r != NO_SLOT) && (s_prev_end == SUM_W'(start_r));
  assign s_gcur = s_g + s_cur_len;
  assign gcur_sat = sat(s_gcur);
  assign s_all  = SUM_W'(prev_len_r) + SUM_W'(gcur_sat);
  assign all_sat = sat(s_all);
  assign s_pg   = SUM_W'(prev_len_r) + s_g;
  assign pg_sat = sat(s_pg);
  assign g_sat  = sat(s_g);
  assign s_tot  = SUM_W'(total_r) + s_g;
  assign tot_sat = sat(s_tot);
  assign tot_sub = (SUM_W'(total_r) >= s_g) ? LEN_W'(SUM_W'(total_r) - s_g) : '0;
  assign pool_p = (pool_r > CLAMP) ? CLAMP : pool_r;

  // status toward the sequencer
  assign sts.req       = req_r;
  assign sts.walk_end  = (cur_r == NO_SLOT) || (steps_r >= MAX_CNT);
  assign sts.stop      = (req_r == ffea_pkg::REQ_ALLOC) ?
                         (SUM_W'(rd_len) >= s_g) : (SUM_W'(rd_start) >= SUM_W'(start_r));
  assign sts.need_link = (prev_r != NO_SLOT) && !mprev && !mnext && (slot_r != NO_SLOT);
  assign sts.out_free  = !out_valid_r || out_ready;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (cmd.boot_wr || cmd.init) begin
      we    = 1'b1;
      wdata = {IW'(0), (cmd.boot_wr ? RESET_P : pool_p), EXT_SW'(0)};
    end else if (cmd.alloc_upd) begin
      we = 1'b1;
      if (s_cur_len == s_g) begin
        we    = (prev_r != NO_SLOT);
        waddr = prev_r[IW-1:0];
        wdata = {((cur_next == NO_SLOT) ? prev_r[IW-1:0] : cur_next[IW-1:0]),
                 prev_len_r, prev_start_r};
      end else begin
        waddr = cur_r[IW-1:0];
        wdata = {cur_link_r, LEN_W'(s_cur_len - s_g), EXT_SW'(s_cur_start + s_g)};
      end
    end else if (cmd.free_upd) begin
      priority if (mprev && mnext) begin
        we    = 1'b1;
        waddr = prev_r[IW-1:0];
        wdata = {((cur_next == NO_SLOT) ? prev_r[IW-1:0] : cur_next[IW-1:0]),
                 all_sat, prev_start_r};
      end else if (mprev) begin
        // keep the previous extent's own link when only its length grows
        we    = 1'b1;
        waddr = prev_r[IW-1:0];
        wdata = {prev_link_r, pg_sat, prev_start_r};
      end else if (mnext) begin
        we    = 1'b1;
        waddr = cur_r[IW-1:0];
        wdata = {cur_link_r, gcur_sat, EXT_SW'(start_r)};
      end else begin
        we    = (slot_r != NO_SLOT);
        waddr = slot_r[IW-1:0];
        wdata = {((cur_r == NO_SLOT) ? slot_r[IW-1:0] : cur_r[IW-1:0]),
                 g_sat, EXT_SW'(start_r)};
      end
    end else if (cmd.link_upd) begin
      we    = 1'b1;
      waddr = prev_r[IW-1:0];
      wdata = {slot_r[IW-1:0], prev_len_r, prev_start_r};
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r      <= ffea_pkg::POOL_RESET;
      head_r      <= (RESET_P != '0) ? '0 : NO_SLOT;
      total_r     <= RESET_P;
      in_use_r    <= MAX_EXTENTS'(RESET_P != '0);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pool_r <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.init) begin
        head_r   <= (pool_p != '0) ? '0 : NO_SLOT;
        total_r  <= pool_p;
        in_use_r <= MAX_EXTENTS'(pool_p != '0);
      end
      if (cmd.alloc_upd) begin
        total_r <= tot_sub;
        if (s_cur_len == s_g) begin
          in_use_r[cur_r[IW-1:0]] <= 1'b0;
          if (prev_r == NO_SLOT) begin
            head_r <= cur_next;
          end
        end
      end
      if (cmd.free_upd) begin
        if (mprev || mnext || (slot_r != NO_SLOT)) begin
          total_r <= tot_sat;
        end
        priority if (mprev && mnext) begin
          in_use_r[cur_r[IW-1:0]] <= 1'b0;
        end else if (mprev || mnext) begin
          head_r <= head_r;
        end else if (slot_r != NO_SLOT) begin
          in_use_r[slot_r[IW-1:0]] <= 1'b1;
          if (prev_r == NO_SLOT) begin
            head_r <= slot_r;
          end
        end
      end
    end
  end

  // walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r        <= ffea_pkg::req_t'(in_req);
      g_r          <= g_in;
      start_r      <= in_off[AB-1:GL];
      cur_r        <= head_r;
      prev_r       <= NO_SLOT;
      steps_r      <= '0;
      slot_r       <= free_slot;
      res_status_r <= ffea_pkg::ST_OK;
      res_ok_r     <= 1'b0;
    end
    if (cmd.eval) begin
      cur_start_r <= rd_start;
      cur_len_r   <= rd_len;
      cur_link_r  <= rd_link;
      if (!sts.stop) begin
        prev_r       <= cur_r;
        prev_start_r <= rd_start;
        prev_len_r   <= rd_len;
        prev_link_r  <= rd_link;
        cur_r        <= rd_next;
        steps_r      <= steps_r + CW'(1);
      end
    end
    if (cmd.close) begin
      cur_r <= NO_SLOT;
      if (req_r == ffea_pkg::REQ_ALLOC) begin
        res_status_r <= ffea_pkg::ST_NOFIT;
      end
    end
    if (cmd.alloc_upd) begin
      res_start_r <= cur_start_r;
      res_ok_r    <= 1'b1;
    end
    if (cmd.free_upd && !mprev && !mnext && (slot_r == NO_SLOT)) begin
      res_status_r <= ffea_pkg::ST_FULL;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_ok_r ? off_bytes(res_start_r) : '0;
      out_avail_r  <= total_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_off    = out_off_r;
  assign out_avail  = out_avail_r;

endmodule

// File: hdl/first_fit_extent_allocator.sv
// Top level of the first-fit extent allocator.
//
// Usage:
//   in_*  : request words. in_tuser carries the request kind (allocate, free,
//           reinitialize); in_tdata carries the byte size and the byte offset.
//   out_* : one result word per request: status in out_tuser, allocated
//           offset and free granule count in out_tdata.
//   cfg_* : pool size in granules, used by reinitialize; write only while idle.
// Walk: an allocate or free walks the address-ordered extent list, with a
//   table read, then a compare for each extent visited, after the accept
//   state; any table update, a free's optional link write and the result
//   load follow. The walk ends at the list end or after MAX_EXTENTS extents.
//   Reinitialize passes through the init and done states. The table read
//   port sets the pace of the walk.
// One request is in flight at a time; a new word is accepted while the last
//   result still waits on out_tready.
// Reset: the boot state writes the single pool extent into slot zero, then
//   in_tready rises. When the receiver stalls, the result is held and the
//   next finished request waits in its last state until the output frees.
`include "assert_macros.svh"
module first_fit_extent_allocator #(
  parameter int MAX_EXTENTS   = ffea_pkg::DEF_MAX_EXTENTS,
  parameter int GRANULE_BYTES = ffea_pkg::DEF_GRANULE_BYTES,
  parameter int ADDR_BITS     = ffea_pkg::DEF_ADDR_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [ffea_pkg::LEN_W-1:0]          cfg_wr_data,   // pool_granules
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffea_pkg::IN_TDATA_W-1:0]     in_tdata,      // size_bytes, block_offset
  input  logic [ffea_pkg::TUSER_W-1:0]        in_tuser,      // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ffea_pkg::OUT_TDATA_W-1:0]    out_tdata,     // alloc_offset, avail_granules, pad
  output logic [ffea_pkg::TUSER_W-1:0]        out_tuser      // status
);

  ffea_pkg::cmd_t   cmd;
  ffea_pkg::sts_t   sts;
  ffea_pkg::state_t state;
  logic [ffea_pkg::OFF_W-1:0] out_off;
  logic [ffea_pkg::LEN_W-1:0] out_avail;

  // sequence the walk and the updates
  ffea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_tuser),
    .sts       (sts),
    .cmd       (cmd),
    .state     (state)
  );

  // hold the table, the walk registers and the result word
  ffea_dp #(
    .MAX_EXTENTS   (MAX_EXTENTS),
    .GRANULE_BYTES (GRANULE_BYTES),
    .ADDR_BITS     (ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_tuser),
    .in_size     (in_tdata[31:0]),
    .in_off      (in_tdata[63:32]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_off     (out_off),
    .out_avail   (out_avail)
  );

  // pack the result word, offset lowest
  assign out_tdata = {6'b0, out_avail, out_off};

  // a failed request never reports an offset
  `ASSERT_IMPL(a_fail_no_off, clk, rst_n, out_tvalid && (out_tuser != ffea_pkg::ST_OK), out_tdata[31:0] == '0)
  // one request at a time: no word is taken right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // only the idle state takes words
  `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, state == ffea_pkg::S_IDLE)

endmodule
